[sv/dirty_rect_history_tracker_assert.svh]
// Assertion macros for the dirty-rectangle history tracker.
`ifndef DIRTY_RECT_HISTORY_TRACKER_ASSERT_SVH
`define DIRTY_RECT_HISTORY_TRACKER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DRHT_ASSERT_IMPLY(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DRHT_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/drht_pkg.sv]
// Shared constants and types of the dirty-rectangle history tracker.
package drht_pkg;

    localparam int RING_DEPTH = 8;
    localparam int COORD_BITS = 12;

    localparam int SIZE_BITS  = COORD_BITS + 1;
    localparam int IMG_BITS   = 13;
    localparam int COUNT_BITS = 32;
    localparam int OP_BITS    = 2;
    localparam int PTR_BITS   = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int REM_BITS   = $clog2(RING_DEPTH + 1);

    localparam int IN_DATA_BITS  = 2 * COORD_BITS + 2 * SIZE_BITS + COUNT_BITS;
    localparam int IN_DATA_W     = ((IN_DATA_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_BITS = COUNT_BITS + 2 * COORD_BITS + 2 * SIZE_BITS;
    localparam int OUT_DATA_W    = ((OUT_DATA_BITS + 7) / 8) * 8;

    localparam logic [SIZE_BITS-1:0] MAX_DIM = SIZE_BITS'(1) << COORD_BITS;

    localparam logic [OP_BITS-1:0] OP_PAINT = 2'd0;
    localparam logic [OP_BITS-1:0] OP_FULL  = 2'd1;
    localparam logic [OP_BITS-1:0] OP_QUERY = 2'd2;

    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [SIZE_BITS-1:0]  w;
        logic [SIZE_BITS-1:0]  h;
    } rect_t;

    // Controller to datapath.
    typedef struct packed {
        logic load;
        logic setup;
        logic step;
        logic emit;
    } cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic walk_needed;
        logic last_step;
        logic out_busy;
    } sts_t;

endpackage

[sv/drht_ctrl.sv]
// Controller state machine of the dirty-rectangle history tracker.
module drht_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  drht_pkg::sts_t  sts,
    output drht_pkg::cmd_t  cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_WALK = 4'b0100,
        S_EMIT = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                state_next = sts.walk_needed ? S_WALK : S_EMIT;
            end
            S_WALK: begin
                if (sts.last_step) begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!sts.out_busy) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign s_tready  = (state_reg == S_IDLE);
    assign cmd.load  = (state_reg == S_IDLE) && s_tvalid;
    assign cmd.setup = (state_reg == S_EXEC);
    assign cmd.step  = (state_reg == S_WALK);
    assign cmd.emit  = (state_reg == S_EMIT) && !sts.out_busy;

endmodule

[sv/drht_dp.sv]
// Datapath of the dirty-rectangle history tracker: configuration, ring, count, union walk, output register.
module drht_dp (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic                                cfg_index,
    input  logic [drht_pkg::IMG_BITS-1:0]       cfg_wdata,
    input  logic [drht_pkg::OP_BITS-1:0]        in_op,
    input  drht_pkg::rect_t                     in_rect,
    input  logic [drht_pkg::COUNT_BITS-1:0]     in_seen,
    input  logic                                m_tready,
    output logic                                m_tvalid,
    output logic [drht_pkg::COUNT_BITS-1:0]     out_count,
    output drht_pkg::rect_t                     out_union,
    output logic                                out_status,
    input  drht_pkg::cmd_t                      cmd,
    output drht_pkg::sts_t                      sts
);

    function automatic logic [drht_pkg::SIZE_BITS-1:0] clamp_dim(
        input logic [drht_pkg::IMG_BITS-1:0] v
    );
        logic [drht_pkg::SIZE_BITS-1:0] r;
        if (v == '0) begin
            r = drht_pkg::SIZE_BITS'(1);
        end else if (v > drht_pkg::IMG_BITS'(drht_pkg::MAX_DIM)) begin
            r = drht_pkg::MAX_DIM;
        end else begin
            r = drht_pkg::SIZE_BITS'(v);
        end
        return r;
    endfunction

    // Bounding box of two rectangles; an empty one adds nothing.
    function automatic drht_pkg::rect_t join_rect(
        input drht_pkg::rect_t a,
        input drht_pkg::rect_t b
    );
        drht_pkg::rect_t r;
        logic [drht_pkg::SIZE_BITS-1:0] ax1, ay1, bx1, by1, x1, y1;
        ax1 = drht_pkg::SIZE_BITS'(a.x) + a.w;
        ay1 = drht_pkg::SIZE_BITS'(a.y) + a.h;
        bx1 = drht_pkg::SIZE_BITS'(b.x) + b.w;
        by1 = drht_pkg::SIZE_BITS'(b.y) + b.h;
        if (a.w == '0 || a.h == '0) begin
            r = b;
        end else if (b.w == '0 || b.h == '0) begin
            r = a;
        end else begin
            r.x = (a.x < b.x) ? a.x : b.x;
            r.y = (a.y < b.y) ? a.y : b.y;
            x1  = (ax1 > bx1) ? ax1 : bx1;
            y1  = (ay1 > by1) ? ay1 : by1;
            r.w = x1 - drht_pkg::SIZE_BITS'(r.x);
            r.h = y1 - drht_pkg::SIZE_BITS'(r.y);
        end
        return r;
    endfunction

    localparam logic [drht_pkg::PTR_BITS-1:0] LAST_SLOT =
        drht_pkg::PTR_BITS'(drht_pkg::RING_DEPTH - 1);

    logic [drht_pkg::IMG_BITS-1:0]   width_reg;
    logic [drht_pkg::IMG_BITS-1:0]   height_reg;
    logic [drht_pkg::COUNT_BITS-1:0] count_reg;
    logic [drht_pkg::PTR_BITS-1:0]   wr_ptr_reg;
    logic [drht_pkg::PTR_BITS-1:0]   rd_ptr_reg;
    logic [drht_pkg::REM_BITS-1:0]   rem_reg;
    drht_pkg::rect_t                 ring_reg [drht_pkg::RING_DEPTH];

    logic [drht_pkg::OP_BITS-1:0]    op_reg;
    drht_pkg::rect_t                 rect_reg;
    logic [drht_pkg::COUNT_BITS-1:0] seen_reg;
    drht_pkg::rect_t                 union_reg;
    logic                            status_reg;

    logic                            m_tvalid_reg;
    logic [drht_pkg::COUNT_BITS-1:0] out_count_reg;
    drht_pkg::rect_t                 out_union_reg;
    logic                            out_status_reg;

    logic [drht_pkg::COUNT_BITS-1:0] behind;
    logic                            too_far;
    logic [drht_pkg::SIZE_BITS:0]    x_end;
    logic [drht_pkg::SIZE_BITS:0]    y_end;
    logic                            rect_empty;
    logic                            out_of_bounds;
    drht_pkg::rect_t                 whole;
    logic                            store;
    drht_pkg::rect_t                 store_rect;

    assign behind  = count_reg - seen_reg;
    assign too_far = behind > drht_pkg::COUNT_BITS'(drht_pkg::RING_DEPTH);

    assign x_end = (drht_pkg::SIZE_BITS+1)'(rect_reg.x) + (drht_pkg::SIZE_BITS+1)'(rect_reg.w);
    assign y_end = (drht_pkg::SIZE_BITS+1)'(rect_reg.y) + (drht_pkg::SIZE_BITS+1)'(rect_reg.h);
    assign rect_empty    = (rect_reg.w == '0) || (rect_reg.h == '0);
    assign out_of_bounds = (x_end > (drht_pkg::SIZE_BITS+1)'(clamp_dim(width_reg)))
                        || (y_end > (drht_pkg::SIZE_BITS+1)'(clamp_dim(height_reg)));

    assign whole.x = '0;
    assign whole.y = '0;
    assign whole.w = clamp_dim(width_reg);
    assign whole.h = clamp_dim(height_reg);

    always_comb begin
        store      = 1'b0;
        store_rect = rect_reg;
        case (op_reg)
            drht_pkg::OP_PAINT: begin
                store = !rect_empty && !out_of_bounds;
            end
            drht_pkg::OP_FULL: begin
                store      = 1'b1;
                store_rect = whole;
            end
            default: begin
                store = 1'b0;
            end
        endcase
    end

    assign sts.walk_needed = (op_reg == drht_pkg::OP_QUERY) && !too_far && (behind != '0);
    assign sts.last_step   = (rem_reg == drht_pkg::REM_BITS'(1));
    assign sts.out_busy    = m_tvalid_reg && !m_tready;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= drht_pkg::IMG_BITS'(4096);
            height_reg <= drht_pkg::IMG_BITS'(4096);
        end else if (cfg_wr_en) begin
            case (cfg_index)
                drht_pkg::CFG_WIDTH:  width_reg  <= cfg_wdata;
                drht_pkg::CFG_HEIGHT: height_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // History ring and paint count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= '0;
            wr_ptr_reg <= '0;
            for (int i = 0; i < drht_pkg::RING_DEPTH; i++) begin
                ring_reg[i] <= '0;
            end
        end else if (cmd.setup && store) begin
            ring_reg[wr_ptr_reg] <= store_rect;
            count_reg  <= count_reg + drht_pkg::COUNT_BITS'(1);
            wr_ptr_reg <= (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + drht_pkg::PTR_BITS'(1);
        end
    end

    // Item registers, walk state and union.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg <= '0;
        end else if (cmd.setup) begin
            rem_reg <= sts.walk_needed ? behind[drht_pkg::REM_BITS-1:0] : '0;
        end else if (cmd.step) begin
            rem_reg <= rem_reg - drht_pkg::REM_BITS'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg   <= in_op;
            rect_reg <= in_rect;
            seen_reg <= in_seen;
        end
        if (cmd.setup) begin
            rd_ptr_reg <= (wr_ptr_reg == '0) ? LAST_SLOT : wr_ptr_reg - drht_pkg::PTR_BITS'(1);
            status_reg <= (op_reg == drht_pkg::OP_PAINT) && !rect_empty && out_of_bounds;
            union_reg  <= ((op_reg == drht_pkg::OP_QUERY) && too_far) ? whole : '0;
        end else if (cmd.step) begin
            union_reg  <= join_rect(union_reg, ring_reg[rd_ptr_reg]);
            rd_ptr_reg <= (rd_ptr_reg == '0) ? LAST_SLOT : rd_ptr_reg - drht_pkg::PTR_BITS'(1);
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_count_reg  <= count_reg;
            out_union_reg  <= union_reg;
            out_status_reg <= status_reg;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign out_count  = out_count_reg;
    assign out_union  = out_union_reg;
    assign out_status = out_status_reg;

endmodule

[sv/dirty_rect_history_tracker.sv]
// Top level of the dirty-rectangle history tracker.
//
//  Channel  Direction  Carries
//  s_*      in         paint / paint-whole-image / query items (op in tuser)
//  m_*      out        one result per item: count and union (status in tuser)
//  cfg_*    in         image_width (index 0), image_height (index 1)
//
// A paint, paint-whole-image or unused-op item passes the states accept, execute
// and emit; its result turns valid when emit loads the output register.
// A query adds walk steps before emit, one per newer paint (0..RING_DEPTH), one entry each.
// One item is in flight at a time; the next is taken once the result sits in
// the output register, and a stalled result holds the following one in emit.
// Reset is synchronous, active low: clear the ring and count, set 4096 x 4096.
`include "dirty_rect_history_tracker_assert.svh"

module dirty_rect_history_tracker (
    input  logic                              aclk,
    input  logic                              aresetn,

    input  logic                              s_tvalid,
    output logic                              s_tready,
    // rect_x, rect_y, rect_w, rect_h, seen_count, zero fill (lowest bit up)
    input  logic [drht_pkg::IN_DATA_W-1:0]    s_tdata,
    // op
    input  logic [drht_pkg::OP_BITS-1:0]      s_tuser,

    output logic                              m_tvalid,
    input  logic                              m_tready,
    // now_count, union_x, union_y, union_w, union_h, zero fill (lowest bit up)
    output logic [drht_pkg::OUT_DATA_W-1:0]   m_tdata,
    // status
    output logic                              m_tuser,

    input  logic                              cfg_wr_en,
    input  logic                              cfg_index,
    input  logic [drht_pkg::IMG_BITS-1:0]     cfg_wdata
);

    localparam int CB = drht_pkg::COORD_BITS;
    localparam int SB = drht_pkg::SIZE_BITS;
    localparam int NB = drht_pkg::COUNT_BITS;

    drht_pkg::cmd_t                  cmd;
    drht_pkg::sts_t                  sts;
    drht_pkg::rect_t                 in_rect;
    logic [NB-1:0]                   in_seen;
    logic [NB-1:0]                   out_count;
    drht_pkg::rect_t                 out_union;
    logic                            out_status;

    // Unpack the input transfer.
    assign in_rect.x = s_tdata[CB-1:0];
    assign in_rect.y = s_tdata[2*CB-1:CB];
    assign in_rect.w = s_tdata[2*CB+SB-1:2*CB];
    assign in_rect.h = s_tdata[2*CB+2*SB-1:2*CB+SB];
    assign in_seen   = s_tdata[2*CB+2*SB+NB-1:2*CB+2*SB];

    drht_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    drht_dp u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .in_op      (s_tuser),
        .in_rect    (in_rect),
        .in_seen    (in_seen),
        .m_tready   (m_tready),
        .m_tvalid   (m_tvalid),
        .out_count  (out_count),
        .out_union  (out_union),
        .out_status (out_status),
        .cmd        (cmd),
        .sts        (sts)
    );

    // Pack the result transfer, lowest field first, zero fill on top.
    assign m_tdata = drht_pkg::OUT_DATA_W'({out_union.h, out_union.w, out_union.y,
                                            out_union.x, out_count});
    assign m_tuser = out_status;

    // One item in flight: an accepted transfer blocks the input next cycle.
    `DRHT_ASSERT_NEXT(a_one_in_flight, aclk, aresetn, s_tvalid && s_tready, !s_tready,
        "input accepted twice in a row")

    // Never load the output register over a stalled result.
    `DRHT_ASSERT_IMPLY(a_emit_free, aclk, aresetn, cmd.emit, !sts.out_busy,
        "result emitted over a stalled output")

    // A new result appears only after the controller emitted it.
    `DRHT_ASSERT_IMPLY(a_valid_from_emit, aclk, aresetn, $rose(m_tvalid), $past(cmd.emit),
        "output valid rose without an emit")

endmodule
